[hdl/ffsa_pkg.sv]
package ffsa_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int ADDR_BITS    = 16;
  localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
  localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
  localparam logic [15:0] RESET_MEMORY = 16'd1000;

  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_RELEASED = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic FN_ALLOC   = 1'b0;
  localparam logic FN_RELEASE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] proc_id;
    logic [15:0] req_size;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_addr;
    logic        compacted;
    logic [15:0] free_total;
  } out_beat_t;

  typedef struct packed {
    logic                 owned;
    logic [15:0]          owner;
    logic [ADDR_BITS-1:0] start;
    logic [15:0]          length;
  } seg_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_SCAN,
    OP_COMPACT,
    OP_SPLIT,
    OP_MERGE,
    OP_REBASE,
    OP_TAIL
  } op_code_t;

  typedef struct packed {
    op_code_t             op;
    logic [IDX_BITS:0]    pos;
    logic [15:0]          id;
    logic [15:0]          size;
    logic [15:0]          total;
    logic [ADDR_BITS-1:0] addr;
    logic                 shift_in;
  } cell_ctl_t;

endpackage

[hdl/ffsa_cell.sv]
module ffsa_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ffsa_pkg::cell_ctl_t ctl,
  input  logic [ffsa_pkg::IDX_BITS-1:0] my_idx,
  input  ffsa_pkg::seg_t    left_seg,
  input  ffsa_pkg::seg_t    right_seg,
  input  logic              right_valid,
  output ffsa_pkg::seg_t    seg
);
  import ffsa_pkg::*;

  seg_t seg_r, seg_nxt;
  logic [IDX_BITS:0] me;

  assign me  = {1'b0, my_idx};
  assign seg = seg_r;

  always_comb begin
    seg_nxt = seg_r;
    unique case (ctl.op)
      OP_INIT: begin
        seg_nxt = '0;
        if (me == '0) seg_nxt.length = ctl.total;
      end
      OP_SPLIT: begin
        if (me > ctl.pos + 1) seg_nxt = left_seg;
        else if (me == ctl.pos + 1) begin
          seg_nxt = seg_t'{1'b0, 16'd0,
                           ADDR_BITS'(left_seg.start + ADDR_BITS'(ctl.size)),
                           16'(left_seg.length - ctl.size)};
        end else if (me == ctl.pos) begin
          seg_nxt.owned = 1'b1;
          seg_nxt.owner = ctl.id;
          seg_nxt.length = ctl.size;
        end
      end
      OP_SCAN: begin
        if (me == ctl.pos) begin
          seg_nxt.owned = 1'b1;
          seg_nxt.owner = ctl.id;
        end
      end
      OP_MERGE: begin
        if (me == ctl.pos) begin
          seg_nxt.owned = 1'b0;
          seg_nxt.owner = 16'd0;
          if (ctl.shift_in) seg_nxt.length = 16'(seg_r.length + right_seg.length);
        end else if (me > ctl.pos && ctl.shift_in) begin
          if (right_valid) seg_nxt = right_seg;
          else seg_nxt = '0;
        end
      end
      OP_COMPACT: begin
        if (me == ctl.pos) begin
          seg_nxt = right_valid ? right_seg : seg_t'('0);
        end else if (me > ctl.pos) begin
          seg_nxt = right_valid ? right_seg : seg_t'('0);
        end
      end
      OP_REBASE: begin
        if (me == ctl.pos) seg_nxt.start = ctl.addr;
      end
      OP_TAIL: begin
        if (me == ctl.pos) seg_nxt = seg_t'{1'b0, 16'd0, ctl.addr, ctl.total};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= seg_t'{1'b0, 16'd0, {ADDR_BITS{1'b0}},
                      (me == '0) ? RESET_MEMORY : 16'd0};
    end else begin
      seg_r <= seg_nxt;
    end
  end

endmodule

[hdl/ffsa_ctrl.sv]
module ffsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffsa_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffsa_pkg::out_beat_t out_data,
  input  ffsa_pkg::seg_t     segs [ffsa_pkg::MAX_SEGMENTS],
  output ffsa_pkg::cell_ctl_t ctl
);
  import ffsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_CPACK, S_CTAIL, S_CFIT, S_REL, S_REL2, S_SUM, S_DONE
  } state_t;

  state_t state_r;
  in_beat_t req_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [IDX_BITS:0] i_r, hit_r, fit_r, n_r;
  logic hit_found_r, fit_found_r, comp_r;
  logic [2:0] status_r;
  logic [ADDR_BITS-1:0] addr_r, caddr_r;
  logic [16:0] sum_r;
  logic [15:0] csum_r;
  out_beat_t out_r;
  logic out_valid_r;
  cell_ctl_t ctl_r;
  seg_t cur;
  logic [IDX_BITS-1:0] ix;
  logic nxt_free;

  assign ix  = i_r[IDX_BITS-1:0];
  assign cur = segs[ix];
  assign nxt_free = ((i_r + 1'b1) < (IDX_BITS+1)'(cnt_r)) && !segs[ix + 1'b1].owned;
  assign ctl = ctl_r;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    op_code_t op_v;
    op_v = OP_HOLD;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= CNT_BITS'(1);
      out_valid_r <= 1'b0;
      ctl_r <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            op_v = OP_INIT;
            ctl_r.total <= cfg_data;
            cnt_r <= CNT_BITS'(1);
          end else if (in_valid && !in_stall) begin
            req_r <= in_data;
            i_r <= '0;
            hit_found_r <= 1'b0;
            fit_found_r <= 1'b0;
            comp_r <= 1'b0;
            addr_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (i_r < (IDX_BITS+1)'(cnt_r)) begin
            if (cur.owned && cur.owner == req_r.proc_id && !hit_found_r) begin
              hit_found_r <= 1'b1;
              hit_r <= i_r;
            end
            if (!cur.owned && cur.length >= req_r.req_size && !fit_found_r) begin
              fit_found_r <= 1'b1;
              fit_r <= i_r;
            end
            i_r <= i_r + 1'b1;
          end else begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (req_r.func == FN_ALLOC) begin
            if (req_r.proc_id == 16'd0 || hit_found_r) begin
              status_r <= ST_DUP;
              state_r <= S_SUM;
            end else if (req_r.req_size == 16'd0) begin
              status_r <= ST_NOSPACE;
              state_r <= S_SUM;
            end else if (fit_found_r) begin
              i_r <= fit_r;
              state_r <= S_CFIT;
            end else begin
              comp_r <= 1'b1;
              i_r <= '0;
              n_r <= '0;
              caddr_r <= '0;
              csum_r <= '0;
              state_r <= S_CPACK;
            end
          end else begin
            if (req_r.proc_id == 16'd0 || !hit_found_r) begin
              status_r <= ST_NOTFOUND;
              state_r <= S_SUM;
            end else begin
              i_r <= hit_r;
              state_r <= S_REL;
            end
          end
        end
        S_CPACK: begin
          if (ctl_r.op == OP_COMPACT) begin
            // hold while the shift lands
          end else if (i_r < (IDX_BITS+1)'(cnt_r)) begin
            if (cur.owned) begin
              op_v = OP_REBASE;
              ctl_r.pos <= i_r;
              ctl_r.addr <= caddr_r;
              i_r <= i_r + 1'b1;
              n_r <= n_r + 1'b1;
              caddr_r <= caddr_r + ADDR_BITS'(cur.length);
            end else begin
              csum_r <= csum_r + cur.length;
              op_v = OP_COMPACT;
              ctl_r.pos <= i_r;
              cnt_r <= cnt_r - 1'b1;
            end
          end else begin
            state_r <= S_CTAIL;
          end
        end
        S_CTAIL: begin
          if ((csum_r != 16'd0 || n_r == '0) && n_r < (IDX_BITS+1)'(MAX_SEGMENTS)) begin
            op_v = OP_TAIL;
            ctl_r.pos <= n_r;
            ctl_r.addr <= caddr_r;
            ctl_r.total <= csum_r;
            cnt_r <= CNT_BITS'(n_r) + 1'b1;
            i_r <= n_r;
            state_r <= S_CFIT;
          end else begin
            cnt_r <= CNT_BITS'(n_r);
            status_r <= ST_NOSPACE;
            state_r <= S_SUM;
          end
        end
        S_CFIT: begin
          if (ctl_r.op == OP_TAIL) begin
            // hold while the tail entry lands
          end else if (cur.owned || cur.length < req_r.req_size) begin
            status_r <= ST_NOSPACE;
            state_r <= S_SUM;
          end else if (cur.length == req_r.req_size) begin
            op_v = OP_SCAN;
            ctl_r.pos <= i_r;
            ctl_r.id <= req_r.proc_id;
            status_r <= ST_ALLOC;
            addr_r <= cur.start;
            state_r <= S_SUM;
          end else if (cnt_r >= CNT_BITS'(MAX_SEGMENTS)) begin
            status_r <= ST_FULL;
            state_r <= S_SUM;
          end else begin
            op_v = OP_SPLIT;
            ctl_r.pos <= i_r;
            ctl_r.id <= req_r.proc_id;
            ctl_r.size <= req_r.req_size;
            cnt_r <= cnt_r + 1'b1;
            status_r <= ST_ALLOC;
            addr_r <= cur.start;
            state_r <= S_SUM;
          end
        end
        S_REL: begin
          status_r <= ST_RELEASED;
          addr_r <= cur.start;
          state_r <= S_REL2;
          op_v = OP_MERGE;
          ctl_r.pos <= i_r;
          ctl_r.shift_in <= nxt_free;
          if (nxt_free) cnt_r <= cnt_r - 1'b1;
        end
        S_REL2: begin
          if (ctl_r.op == OP_HOLD) begin
            if (i_r != '0 && !segs[ix-1'b1].owned) begin
              op_v = OP_MERGE;
              ctl_r.pos <= i_r - 1'b1;
              ctl_r.shift_in <= 1'b1;
              cnt_r <= cnt_r - 1'b1;
            end
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          state_r <= S_DONE;
          i_r <= '0;
          sum_r <= '0;
        end
        S_DONE: begin
          if (ctl_r.op != OP_HOLD) begin
          end else if (i_r < (IDX_BITS+1)'(cnt_r)) begin
            if (!cur.owned) sum_r <= sum_r + 17'(cur.length);
            i_r <= i_r + 1'b1;
          end else if (!out_valid_r) begin
            out_r.status <= status_r;
            out_r.start_addr <= (status_r == ST_ALLOC || status_r == ST_RELEASED)
                                ? addr_r : '0;
            out_r.compacted <= comp_r;
            out_r.free_total <= sum_r[15:0];
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      ctl_r.op <= op_v;
    end
  end

endmodule

[hdl/first_fit_segment_allocator.sv]
// First-fit segment allocator with compaction.
// Input channel in_valid/in_stall/in_data carries one request beat:
// func (allocate or release), proc_id and req_size.
// Output channel out_valid/out_stall/out_data returns one result beat per
// request: status, start_addr, compacted flag and total free units.
// cfg_we/cfg_data write total_memory and reset the table to one free
// segment; write only while the block is idle.
// A request walks the segment table one entry per cycle: one scan pass,
// a compaction pass when no segment fits (each free entry also waits
// while its shift lands), and a pass that sums free space. The next
// request can be taken in the cycle after the result beat leaves.
// The table lives in a chain of cells; shifts on split, merge and
// compaction move all cells past the affected entry by one in the same cycle.
// One request is in flight at a time; in_stall is high while it works or
// while a result waits. A stalled result holds until taken.
// Synchronous reset sets total_memory to 1000 and the table to one free
// segment; no clearing pass is needed.
module first_fit_segment_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffsa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffsa_pkg::out_beat_t out_data
);
  import ffsa_pkg::*;

  cell_ctl_t ctl;
  seg_t segs [MAX_SEGMENTS];

  ffsa_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .segs, .ctl
  );

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    seg_t lft, rgt;
    logic rv;
    if (g == 0) begin : g_l
      assign lft = '0;
    end else begin : g_l
      assign lft = segs[g-1];
    end
    if (g == MAX_SEGMENTS-1) begin : g_r
      assign rgt = '0;
      assign rv  = 1'b0;
    end else begin : g_r
      assign rgt = segs[g+1];
      assign rv  = 1'b1;
    end
    ffsa_cell u_cell (
      .clk, .rst_n, .ctl, .my_idx(IDX_BITS'(g)), .left_seg(lft),
      .right_seg(rgt), .right_valid(rv), .seg(segs[g])
    );
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");
  a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_ALLOC && out_data.status != ST_RELEASED
    |-> out_data.start_addr == '0)
    else $error("nonzero address on error");
`endif

endmodule

[sim/ffsa_checker.sv]
module ffsa_checker
  import ffsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_data,
  output int          fail_count,
  output int          pending,
  output int          accepted,
  output int          n_alloc,
  output int          n_compact,
  output int          n_full
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        tbl_owned [MAX_SEGMENTS];
  logic [15:0] tbl_owner [MAX_SEGMENTS];
  logic [15:0] tbl_start [MAX_SEGMENTS];
  logic [15:0] tbl_len [MAX_SEGMENTS];
  int          tbl_n;
  logic [15:0] mem_size;
  out_beat_t   expected_q[$];

  assign pending = expected_q.size();

  function automatic void table_clear();
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      tbl_owned[i] = 0; tbl_owner[i] = 0; tbl_start[i] = 0; tbl_len[i] = 0;
    end
    tbl_len[0] = mem_size;
    tbl_n = 1;
  endfunction

  function automatic void move_entry(int dst, int src);
    tbl_owned[dst] = tbl_owned[src];
    tbl_owner[dst] = tbl_owner[src];
    tbl_start[dst] = tbl_start[src];
    tbl_len[dst]   = tbl_len[src];
  endfunction

  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < tbl_n; k++) move_entry(k, k + 1);
    tbl_n--;
    tbl_owned[tbl_n] = 0; tbl_owner[tbl_n] = 0; tbl_start[tbl_n] = 0; tbl_len[tbl_n] = 0;
  endfunction

  function automatic logic [15:0] free_units();
    logic [15:0] s;
    s = 0;
    for (int i = 0; i < tbl_n; i++) if (!tbl_owned[i]) s += tbl_len[i];
    return s;
  endfunction

  function automatic logic [2:0] carve(int pos, logic [15:0] id, logic [15:0] size);
    if (tbl_len[pos] == size) begin
      tbl_owned[pos] = 1; tbl_owner[pos] = id;
      return ST_ALLOC;
    end
    if (tbl_n >= MAX_SEGMENTS) return ST_FULL;
    for (int k = tbl_n; k > pos; k--) move_entry(k, k - 1);
    tbl_n++;
    tbl_owned[pos] = 1; tbl_owner[pos] = id; tbl_len[pos] = size;
    tbl_start[pos+1] = tbl_start[pos+1] + size;
    tbl_len[pos+1] = tbl_len[pos+1] - size;
    return ST_ALLOC;
  endfunction

  function automatic void squeeze();
    int cnt, prev;
    logic [15:0] addr;
    logic [31:0] sum;
    cnt = 0; addr = 0; sum = 0; prev = tbl_n;
    for (int i = 0; i < prev; i++) begin
      if (tbl_owned[i]) begin
        move_entry(cnt, i);
        tbl_start[cnt] = addr;
        addr += tbl_len[cnt];
        cnt++;
      end else begin
        sum += tbl_len[i];
      end
    end
    if ((sum > 0 || cnt == 0) && cnt < MAX_SEGMENTS) begin
      tbl_owned[cnt] = 0; tbl_owner[cnt] = 0; tbl_start[cnt] = addr;
      tbl_len[cnt] = sum[15:0];
      cnt++;
    end
    for (int i = cnt; i < prev; i++) begin
      tbl_owned[i] = 0; tbl_owner[i] = 0; tbl_start[i] = 0; tbl_len[i] = 0;
    end
    tbl_n = cnt;
  endfunction

  function automatic out_beat_t serve_request(in_beat_t req);
    out_beat_t r;
    int i;
    bit dup;
    r = '0;
    if (req.func == FN_ALLOC) begin
      dup = (req.proc_id == 0);
      for (int k = 0; k < tbl_n; k++)
        if (tbl_owned[k] && tbl_owner[k] == req.proc_id) dup = 1;
      if (dup) begin
        r.status = ST_DUP;
      end else if (req.req_size == 0) begin
        r.status = ST_NOSPACE;
      end else begin
        r.status = ST_NOSPACE;
        for (i = 0; i < tbl_n; i++)
          if (!tbl_owned[i] && tbl_len[i] >= req.req_size) break;
        if (i < tbl_n) begin
          r.status = carve(i, req.proc_id, req.req_size);
        end else begin
          squeeze();
          r.compacted = 1;
          i = tbl_n - 1;
          if (tbl_n > 0 && !tbl_owned[i] && tbl_len[i] >= req.req_size)
            r.status = carve(i, req.proc_id, req.req_size);
        end
        if (r.status == ST_ALLOC) r.start_addr = tbl_start[i];
      end
    end else begin
      for (i = 0; i < tbl_n; i++)
        if (req.proc_id != 0 && tbl_owned[i] && tbl_owner[i] == req.proc_id) break;
      if (i >= tbl_n) begin
        r.status = ST_NOTFOUND;
      end else begin
        r.status = ST_RELEASED;
        r.start_addr = tbl_start[i];
        tbl_owned[i] = 0; tbl_owner[i] = 0;
        if (i + 1 < tbl_n && !tbl_owned[i+1]) begin
          tbl_len[i] += tbl_len[i+1];
          drop_entry(i + 1);
        end
        if (i > 0 && !tbl_owned[i-1]) begin
          tbl_len[i-1] += tbl_len[i];
          drop_entry(i);
        end
      end
    end
    r.free_total = free_units();
    return r;
  endfunction

  always_ff @(posedge clk) begin
    out_beat_t want, got;
    if (!rst_n) begin
      mem_size = RESET_MEMORY;
      table_clear();
      expected_q.delete();
      fail_count <= 0; accepted <= 0;
      n_alloc <= 0; n_compact <= 0; n_full <= 0;
    end else begin
      if (cfg_we) begin
        mem_size = cfg_data;
        table_clear();
      end
      if (in_valid && !in_stall) begin
        want = serve_request(in_data);
        expected_q.push_back(want);
        accepted <= accepted + 1;
        if (want.status == ST_ALLOC) n_alloc <= n_alloc + 1;
        if (want.compacted) n_compact <= n_compact + 1;
        if (want.status == ST_FULL) n_full <= n_full + 1;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status)
            $error("status: expected %0d, got %0d", want.status, got.status);
          if (got.start_addr !== want.start_addr)
            $error("start_addr: expected %0d, got %0d", want.start_addr, got.start_addr);
          if (got.compacted !== want.compacted)
            $error("compacted: expected %0d, got %0d", want.compacted, got.compacted);
          if (got.free_total !== want.free_total)
            $error("free_total: expected %0d, got %0d", want.free_total, got.free_total);
          if (got !== want) fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

[sim/tb_first_fit_segment_allocator.sv]
module tb_first_fit_segment_allocator;
  import ffsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 3 * MAX_SEGMENTS + 16;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  int          fail_count, pending, accepted, n_alloc, n_compact, n_full;
  bit          quiet_out;
  int          idle_cycles;
  logic [15:0] live_ids[$];

  first_fit_segment_allocator DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ffsa_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .accepted(accepted),
    .n_alloc(n_alloc), .n_compact(n_compact), .n_full(n_full)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int burst;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!quiet_out && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (burst) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_beat(logic fn, logic [15:0] id, logic [15:0] size, bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= '{func: fn, proc_id: id, req_size: size};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_memory(logic [15:0] units);
    settle();
    cfg_we   <= 1;
    cfg_data <= units;
    @(posedge clk);
    cfg_we <= 0;
    live_ids.delete();
  endtask

  function automatic logic [15:0] pick_size(logic [15:0] mem);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return mem;
      2, 3:    return 16'($urandom_range(1, 8));
      default: return 16'($urandom_range(1, (mem < 16'd16 ? 16'd16 : mem) / 16'd6));
    endcase
  endfunction

  task automatic random_phase(int count, logic [15:0] mem, bit gaps);
    logic [15:0] id, size;
    int k;
    for (int n = 0; n < count; n++) begin
      if (live_ids.size() > 0 && $urandom_range(0, 99) < 45) begin
        k = $urandom_range(0, live_ids.size() - 1);
        id = live_ids[k];
        live_ids.delete(k);
        send_beat(FN_RELEASE, id, 16'($urandom()), gaps);
      end else if ($urandom_range(0, 99) < 8) begin
        send_beat(1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), gaps);
      end else if (live_ids.size() > 0 && $urandom_range(0, 99) < 5) begin
        send_beat(FN_ALLOC, live_ids[0], pick_size(mem), gaps);
      end else begin
        id = 16'($urandom_range(1, 65535));
        size = pick_size(mem);
        send_beat(FN_ALLOC, id, size, gaps);
        if (size != 0 && size <= mem) live_ids.push_back(id);
      end
    end
  endtask

  initial begin
    logic [15:0] mems[6];
    rst_n = 0; cfg_we = 0; cfg_data = 0; in_valid = 0; in_data = '0;
    quiet_out = 0;
    mems = '{16'd1000, 16'd1, 16'd65535, 16'd0, 16'd200, 16'd4000};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_beat(FN_ALLOC, 16'd1, 16'd100, 0);
    send_beat(FN_ALLOC, 16'd1, 16'd5, 0);
    send_beat(FN_ALLOC, 16'd0, 16'd5, 0);
    send_beat(FN_ALLOC, 16'd2, 16'd0, 0);
    send_beat(FN_ALLOC, 16'd3, 16'd200, 0);
    send_beat(FN_ALLOC, 16'hFFFF, 16'd300, 0);
    send_beat(FN_RELEASE, 16'd3, 16'hFFFF, 0);
    send_beat(FN_ALLOC, 16'd4, 16'd200, 0);
    send_beat(FN_RELEASE, 16'd1, 16'd0, 0);
    send_beat(FN_ALLOC, 16'd5, 16'd450, 0);
    send_beat(FN_ALLOC, 16'd6, 16'hFFFF, 0);
    send_beat(FN_RELEASE, 16'd0, 16'd0, 0);
    send_beat(FN_RELEASE, 16'd77, 16'd0, 0);
    send_beat(FN_RELEASE, 16'hFFFF, 16'd0, 0);
    send_beat(FN_RELEASE, 16'd4, 16'd0, 0);
    send_beat(FN_RELEASE, 16'd5, 16'd0, 0);

    set_memory(16'd64);
    for (int i = 1; i <= 32; i++) send_beat(FN_ALLOC, 16'(i), 16'd1, 0);
    for (int i = 1; i <= 31; i += 2) send_beat(FN_RELEASE, 16'(i), 16'd0, 0);
    send_beat(FN_ALLOC, 16'd100, 16'd2, 0);
    send_beat(FN_ALLOC, 16'd101, 16'd1, 0);

    set_memory(16'd1);
    send_beat(FN_ALLOC, 16'd9, 16'd1, 0);
    send_beat(FN_RELEASE, 16'd9, 16'd0, 0);

    for (int p = 0; p < 6; p++) begin
      set_memory(mems[p]);
      random_phase(260, mems[p], 1);
    end
    quiet_out = 1;
    set_memory(16'd300);
    random_phase(200, 16'd300, 0);

    settle();
    $display("Covered %0d requests: %0d allocations, %0d compactions, %0d table-full.",
             accepted, n_alloc, n_compact, n_full);
    $display("Memory sizes 0, 1, 64, 200, 300, 1000, 4000 and 65535 with random stalls.");
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[files.f]
hdl/ffsa_pkg.sv
hdl/ffsa_cell.sv
hdl/ffsa_ctrl.sv
hdl/first_fit_segment_allocator.sv
sim/ffsa_checker.sv
sim/tb_first_fit_segment_allocator.sv
